// File: sv/tolg_pkg.sv
// ----------------------------------------------------------------------------
// tolg_pkg
// Types, codes and grid constants for the two-owner life generation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tolg_pkg;

  // grid size; both dimensions are powers of two so row/col wrap is modular
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 128;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 7;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int CELL_AW   = ROW_W + COL_W;

  // sweep position within a row: one extra column on each side for wrap
  localparam int POS_LAST  = GRID_COLS + 1;
  localparam int POS_W     = $clog2(POS_LAST + 1);
  localparam int CNT_W     = 4;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // owner codes
  localparam logic [1:0] OWN_NONE = 2'd0;
  localparam logic [1:0] OWN_P1   = 2'd1;
  localparam logic [1:0] OWN_P2   = 2'd2;
  localparam logic [1:0] OWN_BAD  = 2'd3;

  // read phases of one window column: row above, own row, row below
  localparam logic [1:0] PH_ABOVE = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_BELOW = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             wr_live;
    logic [1:0]       wr_owner;
  } in_t;

  typedef struct packed {
    logic       rd_live;
    logic [1:0] rd_owner;
    logic [1:0] ack_kind;
  } out_t;

  typedef struct packed {
    logic       live;
    logic [1:0] owner;
  } cell_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_DRAIN
  } tolg_state_t;

endpackage

`default_nettype wire

// File: sv/two_owner_life_generation_top.sv
// ----------------------------------------------------------------------------
// two_owner_life_generation_top
// Toroidal two-owner life grid (B3/S23) kept in two banked RAMs, with cell
// write, cell read and one-generation step requests.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  in_t  (req_type, row, col, wr_live, wr_owner)
//  out_      output     out_valid/out_stall out_t (rd_live, rd_owner, ack_kind)
//
//  a write is acknowledged straight from the request; a read waits for the registered RAM read data
//  a step sweeps every row over GRID_COLS+2 window columns: the single RAM read
//    port fetches the three cells of each window column one per cycle
//  the new generation goes to the other bank, which then becomes current
//  after reset a clearing pass over all CELLS addresses zeroes the current bank
//    while in_stall is high
//  a result waits in the output register; the next transaction is taken once the
//    block is idle and that register is empty or being drained
//
`default_nettype none

module two_owner_life_generation_top
  import tolg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  tolg_state_t state_r, state_nxt;

  logic               bank_r;
  logic [CELL_AW-1:0] clr_addr_r;
  logic               in_accept;
  logic               out_free;
  logic               in_grid;
  logic               rd_grid_r;

  // output register
  logic out_valid_r;
  out_t out_data_r;
  logic out_load;
  out_t out_load_data;

  // banked cell memories
  cell_t              mem0 [CELLS];
  cell_t              mem1 [CELLS];
  cell_t              rdata0_r, rdata1_r, cur_rdata;
  logic [CELL_AW-1:0] raddr, waddr;
  cell_t              wdata;
  logic               wr_en, wr_bank;

  // step sweep counters
  logic [ROW_W-1:0] stp_row_r;
  logic [POS_W-1:0] stp_pos_r;
  logic [1:0]       stp_ph_r;
  logic             stp_last;

  // read-return stage
  logic             rv_vld_r;
  logic [1:0]       rv_ph_r;
  logic [POS_W-1:0] rv_pos_r;
  logic [ROW_W-1:0] rv_row_r;
  cell_t            colbuf_r [2];

  // 3x3 window, indexed [column][row]
  cell_t            win_r [3][3];
  logic             win_vld_r;
  logic [COL_W-1:0] win_col_r;
  logic [ROW_W-1:0] win_row_r;

  logic [CNT_W-1:0] n1, n2, nsum;
  logic             nlive;
  cell_t            nv;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_grid = ({1'b0, in_data.row} < (ROW_W + 1)'(GRID_ROWS)) &&
                   ({1'b0, in_data.col} < (COL_W + 1)'(GRID_COLS));

  assign stp_last = (stp_row_r == ROW_W'(GRID_ROWS - 1)) &&
                    (stp_pos_r == POS_W'(POS_LAST)) && (stp_ph_r == PH_BELOW);

  assign cur_rdata = bank_r ? rdata1_r : rdata0_r;

  // read address: the sweep address during a step, else the request address
  // (row above wraps by modular subtract, column -1 and GRID_COLS wrap likewise)
  always_comb begin
    if (state_r == ST_STEP) begin
      raddr = {stp_row_r + ROW_W'(stp_ph_r) - ROW_W'(1),
               COL_W'(stp_pos_r - POS_W'(1))};
    end else begin
      raddr = {in_data.row, in_data.col};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      mem0[waddr] <= wdata;
    end
    rdata0_r <= mem0[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      mem1[waddr] <= wdata;
    end
    rdata1_r <= mem1[raddr];
  end

  // neighbor counts and rule on the window center
  always_comb begin
    n1 = '0;
    n2 = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && win_r[i][j].live) begin
          if (win_r[i][j].owner == OWN_P1) begin
            n1 = n1 + CNT_W'(1);
          end else if (win_r[i][j].owner == OWN_P2) begin
            n2 = n2 + CNT_W'(1);
          end
        end
      end
    end
    nsum  = n1 + n2;
    nlive = win_r[1][1].live ? (nsum == CNT_W'(2) || nsum == CNT_W'(3))
                             : (nsum == CNT_W'(3));
    nv.live  = nlive;
    nv.owner = OWN_NONE;
    if (nlive) begin
      if (n1 > n2) begin
        nv.owner = OWN_P1;
      end else if (n2 > n1) begin
        nv.owner = OWN_P2;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == CELL_AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && in_data.req_type == REQ_READ) begin
          state_nxt = ST_READ;
        end else if (in_accept && in_data.req_type == REQ_STEP) begin
          state_nxt = ST_STEP;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        if (stp_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rv_vld_r && !win_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // outputs: memory write port and result load
  always_comb begin
    wr_en         = 1'b0;
    wr_bank       = bank_r;
    waddr         = {in_data.row, in_data.col};
    wdata         = '0;
    out_load      = 1'b0;
    out_load_data = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        waddr = clr_addr_r;
      end
      ST_IDLE: begin
        if (in_accept && in_data.req_type == REQ_WRITE) begin
          wr_en       = in_grid;
          wdata.live  = in_data.wr_live;
          wdata.owner = (in_data.wr_owner == OWN_BAD) ? OWN_NONE : in_data.wr_owner;
          out_load    = 1'b1;
          out_load_data.ack_kind = REQ_WRITE;
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        out_load_data.ack_kind = REQ_READ;
        if (rd_grid_r) begin
          out_load_data.rd_live  = cur_rdata.live;
          out_load_data.rd_owner = cur_rdata.owner;
        end
      end
      ST_STEP, ST_DRAIN: begin
        wr_en   = win_vld_r;
        wr_bank = !bank_r;
        waddr   = {win_row_r, win_col_r};
        wdata   = nv;
        if (state_r == ST_DRAIN && !rv_vld_r && !win_vld_r) begin
          out_load = 1'b1;
          out_load_data.ack_kind = REQ_STEP;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      bank_r     <= 1'b0;
      clr_addr_r <= '0;
      stp_row_r  <= '0;
      stp_pos_r  <= '0;
      stp_ph_r   <= PH_ABOVE;
      rv_vld_r   <= 1'b0;
      win_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + CELL_AW'(1);
      end
      if (state_r == ST_DRAIN && state_nxt == ST_IDLE) begin
        bank_r <= !bank_r;
      end
      if (state_r == ST_STEP) begin
        if (stp_ph_r == PH_BELOW) begin
          stp_ph_r <= PH_ABOVE;
          if (stp_pos_r == POS_W'(POS_LAST)) begin
            stp_pos_r <= '0;
            stp_row_r <= stp_row_r + ROW_W'(1);
          end else begin
            stp_pos_r <= stp_pos_r + POS_W'(1);
          end
        end else begin
          stp_ph_r <= stp_ph_r + 2'd1;
        end
      end
      rv_vld_r  <= (state_r == ST_STEP);
      win_vld_r <= rv_vld_r && (rv_ph_r == PH_BELOW) && (rv_pos_r >= POS_W'(2));
    end
  end

  // payload registers of the sweep pipeline, plus the read request range flag
  always_ff @(posedge clk) begin
    rv_ph_r  <= stp_ph_r;
    rv_pos_r <= stp_pos_r;
    rv_row_r <= stp_row_r;
    if (state_r == ST_IDLE) begin
      rd_grid_r <= in_grid;
    end
    if (rv_vld_r) begin
      unique case (rv_ph_r)
        PH_ABOVE: colbuf_r[0] <= cur_rdata;
        PH_MID:   colbuf_r[1] <= cur_rdata;
        PH_BELOW: begin
          win_r[0]    <= win_r[1];
          win_r[1]    <= win_r[2];
          win_r[2][0] <= colbuf_r[0];
          win_r[2][1] <= colbuf_r[1];
          win_r[2][2] <= cur_rdata;
          win_col_r   <= COL_W'(rv_pos_r - POS_W'(2));
          win_row_r   <= rv_row_r;
        end
        default: begin
          colbuf_r[0] <= colbuf_r[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/tolg_checker.sv
// ----------------------------------------------------------------------------
// tolg_checker
// Port-level checks for the two-owner life generation block.
// ----------------------------------------------------------------------------
`default_nettype none

module tolg_checker
  import tolg_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  // clearing pass holds off input and output right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input taken or result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a full and stalled output register blocks new transactions
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result register is blocked");

  // a write is acknowledged in the next cycle
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == REQ_WRITE |=>
      out_valid && out_data.ack_kind == REQ_WRITE)
    else $error("write not acknowledged in the next cycle");

  // only reads carry cell data
  a_cell_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ack_kind != REQ_READ |->
      !out_data.rd_live && out_data.rd_owner == OWN_NONE)
    else $error("cell data on a non-read result");

endmodule

bind two_owner_life_generation_top tolg_checker u_tolg_checker (.*);

`default_nettype wire

// File: dv/tb_two_owner_life_generation_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_owner_life_generation_top
// Self-checking bench for the two-owner life grid. A scoreboard keeps its own
// copy of the grid and advances it on every step request, so each write, read
// and step ack is predicted and checked field by field. Traffic is a directed
// corner/wrap-around case followed by random bursts aimed at a dense patch
// straddling the grid corner, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_two_owner_life_generation_top;
  import tolg_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOT_ROW          = GRID_ROWS - 4;
  localparam int HOT_COL          = GRID_COLS - 4;
  localparam int HOT_SPAN         = 8;
  localparam int RANDOM_REQS      = 1250;
  localparam int MAX_RANDOM_STEPS = 14;
  localparam int HOLD_CYCLES      = 400;

  class life_scoreboard;
    cell_t board   [GRID_ROWS][GRID_COLS];
    cell_t scratch [GRID_ROWS][GRID_COLS];
    out_t  acks [$];
    int    errors;

    function new();
      foreach (board[r, c]) board[r][c] = '0;
      errors = 0;
    endfunction

    // all cells update at once from the old board; only owned live cells count
    function void advance_generation();
      int p1, p2, sum, rr, cc;
      bit live_next;
      cell_t nb;
      for (int r = 0; r < GRID_ROWS; r++) begin
        for (int c = 0; c < GRID_COLS; c++) begin
          p1 = 0;
          p2 = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr == 0 && dc == 0) continue;
              rr = (r + dr + GRID_ROWS) % GRID_ROWS;
              cc = (c + dc + GRID_COLS) % GRID_COLS;
              nb = board[rr][cc];
              if (nb.live && nb.owner == OWN_P1) p1++;
              else if (nb.live && nb.owner == OWN_P2) p2++;
            end
          end
          sum = p1 + p2;
          live_next = board[r][c].live ? (sum == 2 || sum == 3) : (sum == 3);
          scratch[r][c].live = live_next;
          if (!live_next || p1 == p2) scratch[r][c].owner = OWN_NONE;
          else if (p1 > p2) scratch[r][c].owner = OWN_P1;
          else scratch[r][c].owner = OWN_P2;
        end
      end
      board = scratch;
    endfunction

    function void note_request(in_t req);
      out_t ack;
      ack = '0;
      ack.ack_kind = req.req_type;
      case (req.req_type)
        REQ_WRITE: begin
          board[req.row][req.col].live  = req.wr_live;
          board[req.row][req.col].owner = (req.wr_owner == OWN_BAD) ? OWN_NONE : req.wr_owner;
        end
        REQ_READ: begin
          ack.rd_live  = board[req.row][req.col].live;
          ack.rd_owner = board[req.row][req.col].owner;
        end
        REQ_STEP: advance_generation();
        default: return;
      endcase
      acks.push_back(ack);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (acks.size() == 0) begin
        report_mismatch("unexpected transaction, ack_kind", got.ack_kind, -1);
        return;
      end
      want = acks.pop_front();
      if (got.rd_live !== want.rd_live) report_mismatch("rd_live", got.rd_live, want.rd_live);
      if (got.rd_owner !== want.rd_owner) report_mismatch("rd_owner", got.rd_owner, want.rd_owner);
      if (got.ack_kind !== want.ack_kind) report_mismatch("ack_kind", got.ack_kind, want.ack_kind);
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  life_scoreboard sb = new();
  int hold_asks   = 0;
  int hold_served = 0;

  two_owner_life_generation_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_t make_req(logic [1:0] kind, int r, int c, bit live,
                                   logic [1:0] owner);
    in_t q;
    q.req_type = kind;
    q.row      = ROW_W'(r);
    q.col      = COL_W'(c);
    q.wr_live  = live;
    q.wr_owner = owner;
    return q;
  endfunction

  // mostly traffic into a patch around the grid corner so generations evolve
  function automatic in_t random_request(bit allow_step);
    in_t q;
    int pick;
    bit hot;
    pick = $urandom_range(0, 199);
    hot  = ($urandom_range(0, 3) != 0);
    q.row = hot ? ROW_W'((HOT_ROW + $urandom_range(0, HOT_SPAN - 1)) % GRID_ROWS)
                : ROW_W'($urandom_range(0, GRID_ROWS - 1));
    q.col = hot ? COL_W'((HOT_COL + $urandom_range(0, HOT_SPAN - 1)) % GRID_COLS)
                : COL_W'($urandom_range(0, GRID_COLS - 1));
    q.wr_live  = ($urandom_range(0, 9) < 6);
    q.wr_owner = 2'($urandom_range(0, 3));
    if (allow_step && pick < 2) q.req_type = REQ_STEP;
    else if (pick < 8) q.req_type = REQ_UNUSED;
    else if (pick < 110) q.req_type = REQ_WRITE;
    else q.req_type = REQ_READ;
    return q;
  endfunction

  task automatic offer(in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(item);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.acks.size() != 0) @(posedge clk);
  endtask

  // reads the six cells around the corner where rows and columns wrap
  task automatic read_corner();
    for (int dr = -2; dr <= 0; dr++) begin
      for (int dc = -1; dc <= 0; dc++) begin
        offer(make_req(REQ_READ, (GRID_ROWS + dr) % GRID_ROWS, (GRID_COLS + dc) % GRID_COLS,
                       1'b0, OWN_NONE));
      end
    end
  endtask

  // receiver: stretches of no stall, light and heavy stall, and long holds on request
  initial begin
    int mode, len, n;
    forever begin
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 80);
        n    = 0;
        while (n < len && hold_asks == hold_served) begin
          @(posedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          n++;
        end
      end
    end
  end

  initial begin
    int sent, steps_left, burst;
    in_t q;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(make_req(REQ_READ, 0, 0, 1'b0, OWN_NONE));
    // three owned live cells meeting across both wraps at the far corner
    offer(make_req(REQ_WRITE, 0, 0, 1'b1, OWN_P1));
    offer(make_req(REQ_WRITE, 0, GRID_COLS - 1, 1'b1, OWN_P2));
    offer(make_req(REQ_WRITE, GRID_ROWS - 1, 0, 1'b1, OWN_P1));
    // dead but owned, and live with bad owner code: neither may be counted
    offer(make_req(REQ_WRITE, GRID_ROWS - 2, GRID_COLS - 1, 1'b0, OWN_P2));
    offer(make_req(REQ_WRITE, GRID_ROWS - 2, 0, 1'b1, OWN_BAD));
    offer(make_req(REQ_UNUSED, GRID_ROWS - 1, GRID_COLS - 1, 1'b1, OWN_BAD));
    offer(make_req(REQ_READ, GRID_ROWS - 2, GRID_COLS - 1, 1'b0, OWN_NONE));
    offer(make_req(REQ_READ, GRID_ROWS - 2, 0, 1'b0, OWN_NONE));
    offer(make_req(REQ_STEP, GRID_ROWS - 1, GRID_COLS - 1, 1'b1, OWN_BAD));
    read_corner();
    offer(make_req(REQ_STEP, 0, 0, 1'b0, OWN_NONE));
    read_corner();
    wait_drained();

    // long output hold while the sender keeps pushing, to back the block up
    sent = 0;
    hold_asks++;
    repeat (40) begin
      q = random_request(1'b0);
      offer(q);
      if (q.req_type != REQ_UNUSED) sent++;
    end

    steps_left = MAX_RANDOM_STEPS;
    while (sent < RANDOM_REQS) begin
      if ($urandom_range(0, 59) == 0) hold_asks++;
      if ($urandom_range(0, 49) == 0) wait_drained();
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        q = random_request(steps_left > 0);
        if (q.req_type == REQ_STEP) steps_left--;
        offer(q);
        if (q.req_type != REQ_UNUSED) sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: two_owner_life_generation_top.f
sv/tolg_pkg.sv
sv/two_owner_life_generation_top.sv
sv/tolg_checker.sv
dv/tb_two_owner_life_generation_top.sv
